[rtl/ssep_pkg.sv]
// Shared types and constants of the signed slot edge player.
package ssep_pkg;

  localparam int unsigned FIFO_DEPTH = 512;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned FILL_W     = $clog2(FIFO_DEPTH);
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned UNIT_W     = 12;
  localparam int unsigned TICKS_W    = BYTE_W + UNIT_W;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned OPC_W      = 3;
  localparam int unsigned ZERO_UNITS = 127;
  localparam int unsigned UNIT_RESET = 800;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic REG_UNIT_TICKS    = 1'b0;
  localparam logic REG_INVERT_LEVEL  = 1'b1;

  typedef enum logic [OPC_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_PUSH    = 3'd1,
    CMD_START   = 3'd2,
    CMD_PAUSE   = 3'd3,
    CMD_RESUME  = 3'd4,
    CMD_STOP    = 3'd5,
    CMD_SRC_END = 3'd6,
    CMD_NONE    = 3'd7
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [BYTE_W-1:0] slot_byte;
  } cmd_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit_ticks;
    logic              invert_level;
  } cfg_t;

endpackage

[rtl/ssep_front.sv]
// Front end: transaction intake, operation decode and command queue.
module ssep_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ssep_pkg::OPC_W-1:0]    in_operation,
  input  logic signed [ssep_pkg::BYTE_W-1:0] in_slot_byte,
  output logic                          cmd_valid,
  input  logic                          cmd_stall,
  output ssep_pkg::cmd_t                cmd
);

  ssep_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push, pop;
  ssep_pkg::cmd_t dec;

  always_comb begin
    dec.slot_byte = in_slot_byte;
    dec.op        = ssep_pkg::cmd_op_t'(in_operation);
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_valid && !cmd_stall;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("command queue count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("command queue count did not advance on push");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("command queue pointers disagree with count");

endmodule

[rtl/ssep_back.sv]
// Back end: slot FIFO, play state machine, slot timer and result register.
module ssep_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ssep_pkg::cfg_t                  cfg,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  ssep_pkg::cmd_t                  cmd,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_level,
  output logic [ssep_pkg::STATUS_W-1:0]   out_play_status,
  output logic                            out_accepted,
  output logic [ssep_pkg::FILL_W-1:0]     out_fifo_fill,
  output logic [ssep_pkg::COUNT_W-1:0]    out_consumed_count
);

  typedef enum logic [ssep_pkg::STATUS_W-1:0] {
    MODE_STOPPED  = 3'd0,
    MODE_READY    = 3'd1,
    MODE_RUNNING  = 3'd2,
    MODE_PAUSED   = 3'd3,
    MODE_FINISHED = 3'd4,
    MODE_UNDERRUN = 3'd5,
    MODE_BADFIRST = 3'd6
  } mode_t;

  localparam int unsigned PW = ssep_pkg::PTR_W;
  localparam int unsigned FW = ssep_pkg::FILL_W;
  localparam int unsigned TW = ssep_pkg::TICKS_W;
  localparam int unsigned BW = ssep_pkg::BYTE_W;

  logic [BW-1:0] mem [ssep_pkg::FIFO_DEPTH];

  mode_t                         mode_r, mode_nxt;
  logic [PW-1:0]                 rp_r, rp_nxt;
  logic [FW-1:0]                 fill_r, fill_nxt;
  logic [TW-1:0]                 rem_r, rem_nxt;
  logic                          pin_r, pin_nxt;
  logic                          src_r, src_nxt;
  logic [ssep_pkg::COUNT_W-1:0]  pop_r, pop_nxt;
  logic [BW-1:0]                 head_r, head_nxt;
  logic [BW-1:0]                 rd_r;
  logic                          out_valid_r;
  logic                          acc;
  logic                          acc_r;
  logic                          lvl_r;
  mode_t                         status_r;
  logic [FW-1:0]                 fill_out_r;
  logic [ssep_pkg::COUNT_W-1:0]  count_out_r;

  logic          exec;
  logic          live;
  logic          we;
  logic [PW-1:0] wa, ra;
  logic [PW:0]   wsum;
  logic [PW-1:0] rp_inc;
  logic [BW-1:0] mag, mult_a;
  logic [TW-1:0] prod;
  logic          head_zero;
  logic          slot_lvl;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(ssep_pkg::FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign cmd_stall = out_valid_r && out_stall;
  assign exec      = cmd_valid && !cmd_stall;

  assign live = (mode_r == MODE_STOPPED) || (mode_r == MODE_READY) ||
                (mode_r == MODE_RUNNING) || (mode_r == MODE_PAUSED);

  assign rp_inc    = ptr_inc(rp_r);
  assign wsum      = {1'b0, rp_r} + (PW + 1)'(fill_r);
  assign wa        = (wsum >= (PW + 1)'(ssep_pkg::FIFO_DEPTH)) ?
                     PW'(wsum - (PW + 1)'(ssep_pkg::FIFO_DEPTH)) : wsum[PW-1:0];
  assign head_zero = (head_r == '0);
  assign mag       = head_r[BW-1] ? (~head_r + BW'(1)) : head_r;
  assign mult_a    = head_zero ? BW'(ssep_pkg::ZERO_UNITS) : mag;
  assign prod      = TW'(mult_a) * TW'(cfg.unit_ticks);
  assign slot_lvl  = ~head_r[BW-1] ^ cfg.invert_level;

  always_comb begin
    mode_nxt = mode_r;
    rp_nxt   = rp_r;
    fill_nxt = fill_r;
    rem_nxt  = rem_r;
    pin_nxt  = pin_r;
    src_nxt  = src_r;
    pop_nxt  = pop_r;
    head_nxt = head_r;
    we       = 1'b0;
    acc      = 1'b0;
    if (exec) begin
      case (cmd.op)
        ssep_pkg::CMD_TICK: begin
          acc = 1'b1;
          if (mode_r == MODE_RUNNING) begin
            if (rem_r > TW'(1)) begin
              rem_nxt = rem_r - TW'(1);
            end else if (fill_r == '0) begin
              rem_nxt  = '0;
              pin_nxt  = 1'b0;
              mode_nxt = src_r ? MODE_FINISHED : MODE_UNDERRUN;
            end else begin
              rp_nxt   = rp_inc;
              fill_nxt = fill_r - FW'(1);
              pop_nxt  = pop_r + 1'b1;
              head_nxt = rd_r;
              rem_nxt  = prod;
              if (!head_zero) begin
                pin_nxt = slot_lvl;
              end
            end
          end
        end
        ssep_pkg::CMD_PUSH: begin
          if (live && !src_r && (fill_r < FW'(ssep_pkg::FIFO_DEPTH - 1))) begin
            we       = 1'b1;
            fill_nxt = fill_r + FW'(1);
            acc      = 1'b1;
            if (fill_r == '0) begin
              head_nxt = cmd.slot_byte;
            end
            if (mode_r == MODE_STOPPED) begin
              mode_nxt = MODE_READY;
            end
          end
        end
        ssep_pkg::CMD_START: begin
          if (mode_r == MODE_READY) begin
            if (fill_r != '0) begin
              rp_nxt   = rp_inc;
              fill_nxt = fill_r - FW'(1);
              pop_nxt  = pop_r + 1'b1;
              head_nxt = rd_r;
            end
            if (fill_r == '0 || head_zero) begin
              mode_nxt = MODE_BADFIRST;
              pin_nxt  = 1'b0;
              rem_nxt  = '0;
            end else begin
              mode_nxt = MODE_RUNNING;
              pin_nxt  = slot_lvl;
              rem_nxt  = prod;
              acc      = 1'b1;
            end
          end
        end
        ssep_pkg::CMD_PAUSE: begin
          if (mode_r == MODE_RUNNING) begin
            mode_nxt = MODE_PAUSED;
            acc      = 1'b1;
          end
        end
        ssep_pkg::CMD_RESUME: begin
          if (mode_r == MODE_PAUSED) begin
            mode_nxt = MODE_RUNNING;
            acc      = 1'b1;
          end
        end
        ssep_pkg::CMD_STOP: begin
          mode_nxt = MODE_STOPPED;
          rp_nxt   = '0;
          fill_nxt = '0;
          rem_nxt  = '0;
          pin_nxt  = 1'b0;
          src_nxt  = 1'b0;
          pop_nxt  = '0;
          acc      = 1'b1;
        end
        ssep_pkg::CMD_SRC_END: begin
          if (live) begin
            src_nxt = 1'b1;
            acc     = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign ra = ptr_inc(rp_nxt);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= cmd.slot_byte;
    end
    if (we && (wa == ra)) begin
      rd_r <= cmd.slot_byte;
    end else begin
      rd_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STOPPED;
      rp_r        <= '0;
      fill_r      <= '0;
      rem_r       <= '0;
      pin_r       <= 1'b0;
      src_r       <= 1'b0;
      pop_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
      rem_r  <= rem_nxt;
      pin_r  <= pin_nxt;
      src_r  <= src_nxt;
      pop_r  <= pop_nxt;
      if (exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    if (exec) begin
      lvl_r       <= pin_nxt;
      status_r    <= mode_nxt;
      acc_r       <= acc;
      fill_out_r  <= fill_nxt;
      count_out_r <= pop_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_level          = lvl_r;
  assign out_play_status    = status_r;
  assign out_accepted       = acc_r;
  assign out_fifo_fill      = fill_out_r;
  assign out_consumed_count = count_out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
                   fill_r <= FW'(ssep_pkg::FIFO_DEPTH - 1))
    else $error("slot FIFO overfilled");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (mode_r == MODE_STOPPED) |-> (fill_r == '0 && pop_r == '0))
    else $error("stopped with bytes or counts left");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (mode_r != MODE_RUNNING && mode_r != MODE_PAUSED) |-> (rem_r == '0))
    else $error("slot time left outside a slot");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (mode_r == MODE_FINISHED || mode_r == MODE_UNDERRUN ||
                    mode_r == MODE_BADFIRST) |-> !pin_r)
    else $error("level high after playback ended");

endmodule

[rtl/signed_slot_edge_player.sv]
// Top level of the signed slot edge player: register port, front end and back end.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_operation, in_slot_byte
//  out_    | output    | out_valid/out_stall| out_level, out_play_status, out_accepted,
//          |           |                    | out_fifo_fill, out_consumed_count
//  cfg     | register  | psel/penable/pready| paddr, pwdata, prdata (0: unit_ticks,
//          |           |                    | 4: invert_level)
//
//  One transaction per clock cycle is accepted and one result per cycle delivered
//  while out_stall is low. A transaction is registered first in the command queue and
//  then in the result register of the back end, whose single-step update sets the rate.
//  Reset is synchronous and active low; the slot FIFO needs no clearing pass.
//  in_stall rises only while the two-entry command queue is full, which happens
//  only after out_stall has held the result register.
module signed_slot_edge_player (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ssep_pkg::OPC_W-1:0]            in_operation,
  input  logic signed [ssep_pkg::BYTE_W-1:0]    in_slot_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_level,
  output logic [ssep_pkg::STATUS_W-1:0]         out_play_status,
  output logic                                  out_accepted,
  output logic [ssep_pkg::FILL_W-1:0]           out_fifo_fill,
  output logic [ssep_pkg::COUNT_W-1:0]          out_consumed_count,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ssep_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [ssep_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [ssep_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  ssep_pkg::cfg_t cfg_r, cfg_nxt;
  logic           cfg_wr;
  logic           cfg_sel;
  logic           cmd_valid;
  logic           cmd_stall;
  ssep_pkg::cmd_t cmd;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (cfg_sel)
        ssep_pkg::REG_UNIT_TICKS:   cfg_nxt.unit_ticks   = pwdata[ssep_pkg::UNIT_W-1:0];
        ssep_pkg::REG_INVERT_LEVEL: cfg_nxt.invert_level = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      ssep_pkg::REG_UNIT_TICKS:
        prdata = ssep_pkg::CFG_DATA_W'(cfg_r.unit_ticks);
      ssep_pkg::REG_INVERT_LEVEL:
        prdata = ssep_pkg::CFG_DATA_W'(cfg_r.invert_level);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_ticks   <= ssep_pkg::UNIT_W'(ssep_pkg::UNIT_RESET);
      cfg_r.invert_level <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ssep_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_slot_byte (in_slot_byte),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd)
  );

  ssep_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .cmd_valid          (cmd_valid),
    .cmd_stall          (cmd_stall),
    .cmd                (cmd),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_level          (out_level),
    .out_play_status    (out_play_status),
    .out_accepted       (out_accepted),
    .out_fifo_fill      (out_fifo_fill),
    .out_consumed_count (out_consumed_count)
  );

endmodule
